/* src/dwrc_pkg.sv */
package dwrc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int SHORT_DEPTH = 512;
   localparam int LONG_DEPTH = 4096;

   localparam int SHORT_ADDR_BITS = $clog2(SHORT_DEPTH);
   localparam int LONG_ADDR_BITS = $clog2(LONG_DEPTH);
   localparam int SHORT_LEN_BITS = $clog2(SHORT_DEPTH + 1);
   localparam int LONG_LEN_BITS = $clog2(LONG_DEPTH + 1);
   localparam int SHORT_SUM_BITS = SAMPLE_BITS + SHORT_ADDR_BITS;
   localparam int LONG_SUM_BITS = SAMPLE_BITS + LONG_ADDR_BITS;

   localparam logic [SHORT_LEN_BITS-1:0] SHORT_LEN_RESET = SHORT_LEN_BITS'(430);
   localparam logic [LONG_LEN_BITS-1:0] LONG_LEN_RESET = LONG_LEN_BITS'(2583);

   localparam int Q_FRAC = 16;
   localparam int REL_BITS = 32;
   localparam int REL_NUM_BITS = SAMPLE_BITS + 1 + Q_FRAC;

   localparam int SUM_MAX_BITS =
      (LONG_SUM_BITS > SHORT_SUM_BITS) ? LONG_SUM_BITS : SHORT_SUM_BITS;
   localparam int MAG_RAW = (SUM_MAX_BITS > REL_NUM_BITS) ? SUM_MAX_BITS : REL_NUM_BITS;
   localparam int MAG_BITS = MAG_RAW + (MAG_RAW % 2);
   localparam int NUM_BITS = MAG_BITS + 1;
   localparam int DEN_BITS =
      (SAMPLE_BITS > LONG_LEN_BITS + 1) ? SAMPLE_BITS : LONG_LEN_BITS + 1;
   localparam int DIV_STEPS = MAG_BITS / 2;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [REL_BITS-1:0] REL_MAX = {1'b0, {(REL_BITS-1){1'b1}}};
   localparam logic [REL_BITS-1:0] REL_MIN = {1'b1, {(REL_BITS-1){1'b0}}};

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = LONG_LEN_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_LENGTH = CSR_INDEX_BITS'(1);

   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * SAMPLE_BITS + REL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_FIX  = 3'b100
   } div_state_type;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_UPDATE    = 6'b000010,
      ST_DIV_SHORT = 6'b000100,
      ST_DIV_LONG  = 6'b001000,
      ST_DIV_REL   = 6'b010000,
      ST_OUT       = 6'b100000
   } state_type;

endpackage

/* src/dwrc_ram.sv */
module dwrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dwrc_div.sv */
module dwrc_div
   import dwrc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic signed [DEN_BITS-1:0] den,
   output logic                       done,
   output logic signed [NUM_BITS-1:0] quo
);

   div_state_type             state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [DEN_BITS:0]         rem_ff, rem_in;
   logic [MAG_BITS-1:0]       q_ff, q_in;
   logic [DEN_BITS-1:0]       den_ff, den_in;
   logic                      neg_ff, neg_in;
   logic signed [NUM_BITS-1:0] quo_ff, quo_in;
   logic [NUM_BITS-1:0]       num_mag;
   logic [DEN_BITS-1:0]       den_mag;
   logic [DEN_BITS:0]         rem_w;
   logic [DEN_BITS:0]         rem_t;
   logic [MAG_BITS-1:0]       q_w;
   logic [NUM_BITS-1:0]       q_ext;

   assign num_mag = num[NUM_BITS-1] ? (~num + 1'b1) : num;
   assign den_mag = den[DEN_BITS-1] ? (~den + 1'b1) : den;

   // two restoring steps per cycle
   always_comb begin
      rem_w = rem_ff;
      q_w = q_ff;
      rem_t = rem_ff;
      for (int k = 0; k < 2; k++) begin
         rem_t = {rem_w[DEN_BITS-1:0], q_w[MAG_BITS-1]};
         q_w = {q_w[MAG_BITS-2:0], 1'b0};
         if (rem_t >= {1'b0, den_ff}) begin
            rem_t = rem_t - {1'b0, den_ff};
            q_w[0] = 1'b1;
         end
         rem_w = rem_t;
      end
   end

   assign q_ext = {1'b0, q_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      if (start) begin
         state_in = DV_RUN;
         cnt_in = DIV_CNT_BITS'(DIV_STEPS - 1);
         rem_in = '0;
         q_in = num_mag[MAG_BITS-1:0];
         den_in = den_mag;
         neg_in = num[NUM_BITS-1] ^ den[DEN_BITS-1];
      end else begin
         unique case (state_ff)
            DV_IDLE: begin
            end
            DV_RUN: begin
               rem_in = rem_w;
               q_in = q_w;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = DV_FIX;
               end
            end
            DV_FIX: begin
               quo_in = neg_ff ? signed'(~q_ext + 1'b1) : signed'(q_ext);
               done_in = 1'b1;
               state_in = DV_IDLE;
            end
            default: begin
               state_in = DV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule

/* src/dual_window_relative_change.sv */
// Short/long moving-average ratio. Each req beat carries one signed sample; the block
// pushes it into a short and a long ring buffer held in block RAM, updates both running
// totals and fill counts, and returns one rsp beat with both means (total over fill
// count, truncated toward zero) and the relative change (short - long) / long in Q16.16,
// saturated, zero when the long mean is zero. Steps per item: the accept cycle reads
// both RAMs, then comes the update state. Three signed divisions follow in turn on a
// shared divider that does two restoring steps a cycle. Each division goes through a
// start, the restoring steps, a sign fix and a done strobe. Then the output register
// is loaded. When the long mean is zero the third division is skipped. A req beat is
// accepted only while the block is idle, so a new sample waits until the output
// register is loaded. A finished result waits in the output register without holding
// up the next sample, but a result that is still waiting there holds the block in its
// last cycle until the register frees. Writing a length register clears that window at
// once (total, position and fill count); never-written RAM entries read as zero through
// the fill count, so no clearing pass is needed after reset or a length write.
module dual_window_relative_change
   import dwrc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // sample
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,  // short_mean, long_mean, change_q16
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   state_type                        state_ff, state_in;
   logic [SHORT_LEN_BITS-1:0]        short_len_ff;
   logic [LONG_LEN_BITS-1:0]         long_len_ff;
   logic signed [SHORT_SUM_BITS-1:0] short_sum_ff, short_sum_in;
   logic signed [LONG_SUM_BITS-1:0]  long_sum_ff, long_sum_in;
   logic [SHORT_ADDR_BITS-1:0]       short_pos_ff, short_pos_in;
   logic [LONG_ADDR_BITS-1:0]        long_pos_ff, long_pos_in;
   logic [SHORT_LEN_BITS-1:0]        short_fill_ff, short_fill_in;
   logic [LONG_LEN_BITS-1:0]         long_fill_ff, long_fill_in;
   logic signed [SAMPLE_BITS-1:0]    sample_ff;
   logic signed [SAMPLE_BITS-1:0]    sm_ff, lm_ff;
   logic [REL_BITS-1:0]              rel_ff;
   logic                             div_start_ff, div_start_in;
   logic                             rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0]         rsp_data_ff;

   logic [SHORT_LEN_BITS-1:0]        short_len_eff;
   logic [LONG_LEN_BITS-1:0]         long_len_eff;
   logic [SAMPLE_BITS-1:0]           short_rd, long_rd;
   logic signed [SAMPLE_BITS-1:0]    short_old, long_old;
   logic [SHORT_LEN_BITS-1:0]        short_next;
   logic [LONG_LEN_BITS-1:0]         long_next;
   logic                             accept;
   logic                             csr_write;
   logic                             out_load;
   logic signed [SAMPLE_BITS:0]      rel_diff;
   logic signed [NUM_BITS-1:0]       div_num;
   logic signed [DEN_BITS-1:0]       div_den;
   logic                             div_done;
   logic signed [NUM_BITS-1:0]       div_quo;
   logic [NUM_BITS-REL_BITS:0]       quo_high;
   logic [REL_BITS-1:0]              rel_sat;

   assign accept = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      priority if (short_len_ff == '0) begin
         short_len_eff = SHORT_LEN_BITS'(1);
      end else if (short_len_ff > SHORT_LEN_BITS'(SHORT_DEPTH)) begin
         short_len_eff = SHORT_LEN_BITS'(SHORT_DEPTH);
      end else begin
         short_len_eff = short_len_ff;
      end
      priority if (long_len_ff == '0) begin
         long_len_eff = LONG_LEN_BITS'(1);
      end else if (long_len_ff > LONG_LEN_BITS'(LONG_DEPTH)) begin
         long_len_eff = LONG_LEN_BITS'(LONG_DEPTH);
      end else begin
         long_len_eff = long_len_ff;
      end
   end

   dwrc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (SHORT_DEPTH)
   ) u_short_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (short_pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (short_pos_ff),
      .rd_data (short_rd)
   );

   dwrc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LONG_DEPTH)
   ) u_long_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (long_pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (long_pos_ff),
      .rd_data (long_rd)
   );

   // an entry beyond the fill count holds no sample of this window and counts as zero
   assign short_old = (short_fill_ff == short_len_eff) ? signed'(short_rd) : '0;
   assign long_old = (long_fill_ff == long_len_eff) ? signed'(long_rd) : '0;

   assign short_next = {1'b0, short_pos_ff} + 1'b1;
   assign long_next = {1'b0, long_pos_ff} + 1'b1;

   always_comb begin
      short_sum_in = short_sum_ff - SHORT_SUM_BITS'(short_old) + SHORT_SUM_BITS'(sample_ff);
      long_sum_in = long_sum_ff - LONG_SUM_BITS'(long_old) + LONG_SUM_BITS'(sample_ff);
      short_pos_in = (short_next >= short_len_eff) ? '0 : short_next[SHORT_ADDR_BITS-1:0];
      long_pos_in = (long_next >= long_len_eff) ? '0 : long_next[LONG_ADDR_BITS-1:0];
      short_fill_in = (short_fill_ff < short_len_eff) ? short_fill_ff + 1'b1 : short_fill_ff;
      long_fill_in = (long_fill_ff < long_len_eff) ? long_fill_ff + 1'b1 : long_fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff <= SHORT_LEN_RESET;
         long_len_ff <= LONG_LEN_RESET;
         short_sum_ff <= '0;
         long_sum_ff <= '0;
         short_pos_ff <= '0;
         long_pos_ff <= '0;
         short_fill_ff <= '0;
         long_fill_ff <= '0;
      end else begin
         if (csr_write && csr_index == CSR_SHORT_LENGTH) begin
            short_len_ff <= csr_data[SHORT_LEN_BITS-1:0];
            short_sum_ff <= '0;
            short_pos_ff <= '0;
            short_fill_ff <= '0;
         end else if (state_ff == ST_UPDATE) begin
            short_sum_ff <= short_sum_in;
            short_pos_ff <= short_pos_in;
            short_fill_ff <= short_fill_in;
         end
         if (csr_write && csr_index == CSR_LONG_LENGTH) begin
            long_len_ff <= csr_data;
            long_sum_ff <= '0;
            long_pos_ff <= '0;
            long_fill_ff <= '0;
         end else if (state_ff == ST_UPDATE) begin
            long_sum_ff <= long_sum_in;
            long_pos_ff <= long_pos_in;
            long_fill_ff <= long_fill_in;
         end
      end
   end

   // divider operands
   assign rel_diff = {sm_ff[SAMPLE_BITS-1], sm_ff} - {lm_ff[SAMPLE_BITS-1], lm_ff};

   always_comb begin
      unique case (state_ff)
         ST_DIV_SHORT: begin
            div_num = NUM_BITS'(short_sum_ff);
            div_den = DEN_BITS'(short_fill_ff);
         end
         ST_DIV_LONG: begin
            div_num = NUM_BITS'(long_sum_ff);
            div_den = DEN_BITS'(long_fill_ff);
         end
         default: begin
            div_num = {{(NUM_BITS-Q_FRAC-SAMPLE_BITS-1){rel_diff[SAMPLE_BITS]}},
                       rel_diff, {Q_FRAC{1'b0}}};
            div_den = DEN_BITS'(lm_ff);
         end
      endcase
   end

   dwrc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign quo_high = div_quo[NUM_BITS-1:REL_BITS-1];
   assign rel_sat = ((&quo_high) || !(|quo_high)) ? div_quo[REL_BITS-1:0] :
                    (div_quo[NUM_BITS-1] ? REL_MIN : REL_MAX);

   always_comb begin
      state_in = state_ff;
      div_start_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DIV_SHORT;
            div_start_in = 1'b1;
         end
         ST_DIV_SHORT: begin
            if (div_done) begin
               state_in = ST_DIV_LONG;
               div_start_in = 1'b1;
            end
         end
         ST_DIV_LONG: begin
            if (div_done) begin
               if (div_quo == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV_REL;
                  div_start_in = 1'b1;
               end
            end
         end
         ST_DIV_REL: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_start_ff <= div_start_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (state_ff == ST_DIV_SHORT && div_done) begin
         sm_ff <= div_quo[SAMPLE_BITS-1:0];
      end
      if (state_ff == ST_DIV_LONG && div_done) begin
         lm_ff <= div_quo[SAMPLE_BITS-1:0];
         rel_ff <= '0;
      end
      if (state_ff == ST_DIV_REL && div_done) begin
         rel_ff <= rel_sat;
      end
      if (out_load) begin
         rsp_data_ff <= RSP_DATA_BITS'({rel_ff, lm_ff, sm_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
